// ===== design/fmdrl_pkg.sv =====
// Package for the fault monitor with debounce and report rate limiting.
// Types, codes and reset constants. No dependencies.
package fmdrl_pkg;

    localparam int NSUB   = 6;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 2;

    typedef logic [TIME_W-1:0] ms_t;
    typedef logic [NSUB-1:0]   sub_mask_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [2:0] {
        KIND_LINK     = 3'd0,
        KIND_POS      = 3'd1,
        KIND_HEADING  = 3'd2,
        KIND_INERTIAL = 3'd3,
        KIND_ANGLE    = 3'd4,
        KIND_SAFETY   = 3'd5,
        KIND_ALL_OK   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        SEV_OK   = 2'd0,
        SEV_WARN = 2'd1,
        SEV_ERR  = 2'd2
    } sev_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_RESEND   = 2'd1,
        CFG_MIN_GAP  = 2'd2
    } cfg_idx_t;

    localparam ms_t DEBOUNCE_RST = 32'd3000;
    localparam ms_t RESEND_RST   = 32'd10000;
    localparam ms_t MIN_GAP_RST  = 32'd2000;

    function automatic sev_t sev_of(input kind_t k);
        sev_t s;
        case (k)
            KIND_LINK, KIND_SAFETY: s = SEV_ERR;
            KIND_POS, KIND_HEADING, KIND_INERTIAL, KIND_ANGLE: s = SEV_WARN;
            default: s = SEV_OK;
        endcase
        return s;
    endfunction

endpackage

// ===== design/fault_monitor_debounce_rate_limit.sv =====
// Fault monitor top level: per-subsystem fault latching, debounce, resend and
// global gap limiting, one report beat per input beat. Depends on fmdrl_pkg.
// An input beat goes through the input register, then the result register.
// Throughput: one beat per cycle while m_tready does not stall the output; the
// state update is one registered pass of six parallel timestamp compares and a
// priority pick. Reset: aresetn synchronous, clears faults and the last-report
// time and loads the register defaults 3000 / 10000 / 2000 ms.
module fault_monitor_debounce_rate_limit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // now_ms[31:0], link_ok, pos_fix_ok, heading_fix_ok, safety circuit,
    // angle_sensor_ok, inertial_ok, zero pad
    input  logic [fmdrl_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // report_valid, report_severity[1:0], fault_count[2:0], fault_mask[5:0], pad
    output logic [fmdrl_pkg::M_TDATA_W-1:0]       m_tdata,
    // report_kind[2:0]
    output logic [fmdrl_pkg::M_TUSER_W-1:0]       m_tuser,
    input  logic                                  cfg_we,
    input  logic [fmdrl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fmdrl_pkg::TIME_W-1:0]          cfg_data
);

    fmdrl_pkg::ms_t debounce_reg, resend_reg, min_gap_reg;

    logic                           in_valid_reg;
    logic [fmdrl_pkg::S_TDATA_W-1:0] in_data_reg;
    logic                           out_valid_reg;
    logic [fmdrl_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [fmdrl_pkg::M_TUSER_W-1:0] out_user_reg, out_user_next;
    logic                           advance;

    fmdrl_pkg::sub_mask_t fault_active_reg, fault_active_next;
    fmdrl_pkg::sub_mask_t reported_reg, reported_next;
    fmdrl_pkg::ms_t       onset_reg [fmdrl_pkg::NSUB];
    fmdrl_pkg::ms_t       onset_next [fmdrl_pkg::NSUB];
    fmdrl_pkg::ms_t       last_rep_reg [fmdrl_pkg::NSUB];
    fmdrl_pkg::ms_t       last_rep_next [fmdrl_pkg::NSUB];
    fmdrl_pkg::ms_t       last_any_reg, last_any_next;
    logic                 had_faults_reg, had_faults_next;

    fmdrl_pkg::ms_t       now;
    fmdrl_pkg::sub_mask_t ok;
    fmdrl_pkg::sub_mask_t due;
    fmdrl_pkg::cnt_t      count;
    logic                 gap_ok;
    logic                 found;
    fmdrl_pkg::kind_t     pick;
    logic                 rep_valid;
    fmdrl_pkg::kind_t     rep_kind;
    fmdrl_pkg::sev_t      rep_sev;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign now   = in_data_reg[31:0];
    assign ok[0] = in_data_reg[32];
    assign ok[1] = in_data_reg[33];
    assign ok[2] = in_data_reg[34];
    assign ok[5] = in_data_reg[35];
    assign ok[4] = in_data_reg[36];
    assign ok[3] = in_data_reg[37];

    assign gap_ok = (now - last_any_reg) >= min_gap_reg;

    always_comb begin
        for (int i = 0; i < fmdrl_pkg::NSUB; i++) begin
            fault_active_next[i] = !ok[i];
            onset_next[i]        = (!ok[i] && !fault_active_reg[i]) ? now : onset_reg[i];
            reported_next[i]     = ok[i] ? 1'b0 : reported_reg[i];
            last_rep_next[i]     = ok[i] ? '0 : last_rep_reg[i];
            due[i] = fault_active_next[i]
                && ((now - onset_next[i]) >= debounce_reg)
                && (!reported_next[i] || ((now - last_rep_next[i]) >= resend_reg));
        end

        count = '0;
        for (int i = 0; i < fmdrl_pkg::NSUB; i++) begin
            count = count + fmdrl_pkg::cnt_t'(fault_active_next[i]);
        end

        found = 1'b0;
        pick  = fmdrl_pkg::KIND_LINK;
        for (int i = fmdrl_pkg::NSUB - 1; i >= 0; i--) begin
            if (due[i]) begin
                found = 1'b1;
                pick  = fmdrl_pkg::kind_t'(i);
            end
        end

        rep_valid       = 1'b0;
        rep_kind        = fmdrl_pkg::KIND_LINK;
        rep_sev         = fmdrl_pkg::SEV_OK;
        last_any_next   = last_any_reg;
        had_faults_next = had_faults_reg;

        if (found && gap_ok) begin
            rep_valid     = 1'b1;
            rep_kind      = pick;
            rep_sev       = fmdrl_pkg::sev_of(pick);
            last_any_next = now;
            for (int i = 0; i < fmdrl_pkg::NSUB; i++) begin
                if (fmdrl_pkg::kind_t'(i) == pick) begin
                    last_rep_next[i] = now;
                    reported_next[i] = 1'b1;
                end
            end
        end

        if (count != '0) begin
            had_faults_next = 1'b1;
        end else if (had_faults_reg) begin
            had_faults_next = 1'b0;
            if (gap_ok) begin
                rep_valid     = 1'b1;
                rep_kind      = fmdrl_pkg::KIND_ALL_OK;
                rep_sev       = fmdrl_pkg::SEV_OK;
                last_any_next = now;
            end
        end

        out_data_next = {4'b0000, fault_active_next, count, rep_sev, rep_valid};
        out_user_next = rep_kind;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= fmdrl_pkg::DEBOUNCE_RST;
            resend_reg   <= fmdrl_pkg::RESEND_RST;
            min_gap_reg  <= fmdrl_pkg::MIN_GAP_RST;
        end else if (cfg_we) begin
            case (fmdrl_pkg::cfg_idx_t'(cfg_index))
                fmdrl_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data;
                fmdrl_pkg::CFG_RESEND:   resend_reg   <= cfg_data;
                fmdrl_pkg::CFG_MIN_GAP:  min_gap_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // onset / last_rep are only read behind fault_active / reported
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            for (int i = 0; i < fmdrl_pkg::NSUB; i++) begin
                onset_reg[i]    <= onset_next[i];
                last_rep_reg[i] <= last_rep_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_active_reg <= '0;
            reported_reg     <= '0;
            last_any_reg     <= '0;
            had_faults_reg   <= 1'b0;
        end else if (advance) begin
            fault_active_reg <= fault_active_next;
            reported_reg     <= reported_next;
            last_any_reg     <= last_any_next;
            had_faults_reg   <= had_faults_next;
        end
    end

endmodule
